FILE: hdl/mwcs_pkg.sv
// Shared widths, codes and state type for the MW cycle slip detector.
package mwcs_pkg;

  localparam int SAT_IDX_W = 6;
  localparam int SYS_W     = 3;
  localparam int EPOCH_W   = 40;
  localparam int MW_W      = 40;
  localparam int LLI_W     = 3;
  localparam int DEV_W     = MW_W + 1;
  localparam int THR_W     = 39;
  localparam int GAP_W     = 32;
  localparam int CFG_W     = 39;
  localparam int CFG_IDX_W = 2;

  localparam int S_TDATA_W = 96;
  localparam int S_TUSER_W = 4;
  localparam int M_TDATA_W = 8;
  localparam int M_TUSER_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SLIP_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP_MS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WANTED_SYSTEM  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_MISSING   = 2'd3;

  localparam logic [THR_W-1:0] SLIP_THRESHOLD_RST = 39'd262144;
  localparam logic [GAP_W-1:0] MAX_GAP_MS_RST     = 32'd61000;
  localparam logic [SYS_W-1:0] WANTED_SYSTEM_RST  = 3'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_TEST,
    ST_DIV,
    ST_WRITE,
    ST_DONE
  } state_t;

endpackage

FILE: hdl/mwcs_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module mwcs_div
  import mwcs_pkg::*;
#(
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DEV_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [DEV_W-1:0] quo
);

  localparam int STEP_W = $clog2(DEV_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DEV_W - 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W+1:0]  trial;
  logic              fits;

  assign rem_sh = {rem, quo[DEV_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, den};
  assign fits   = ~trial[DEN_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (busy) begin
      rem <= fits ? trial[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo <= {quo[DEV_W-2:0], fits};
    end
  end

endmodule

FILE: hdl/mwcs_mem.sv
// Per-slot state memory: last epoch, running mean and window count.
module mwcs_mem #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 96
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/mw_cycle_slip_detector.sv
// Top level of the Melbourne-Wubbena cycle slip detector.
//
//  channel  direction  handshake             content
//  s_*      in         s_tvalid / s_tready   one MW observation
//  m_*      out        m_tvalid / m_tready   slip / rejected / skipped flags
//  cfg_*    in         cfg_wr                register writes, no read-back
//
// One transaction at a time: a tracked observation goes read, diff, test, the 41-step serial
// divider that updates the running mean, write, done; a skipped or missing item goes read,
// done; a restarted one (slip, first sighting or single-sample window) skips the divider.
// No clearing pass: reset clears all the seen flags together.
// A result waiting on m_tready lets the next observation be processed, but not leave ST_DONE.
module mw_cycle_slip_detector
  import mwcs_pkg::*;
#(
  parameter int              NUM_SATS   = 64,
  parameter longint unsigned WINDOW_MAX = 65535
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [5:0] sat_index, [45:6] epoch_ms, [85:46] mw_value, [88:86] lli_first,
  // [91:89] lli_second, [92] prior_slip, [95:93] zero
  input  logic [S_TDATA_W-1:0] s_tdata,
  // [2:0] sat_system, [3] mw_present
  input  logic [S_TUSER_W-1:0] s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [0] slip, [7:1] zero
  output logic [M_TDATA_W-1:0] m_tdata,
  // [0] rejected, [1] skipped
  output logic [M_TUSER_W-1:0] m_tuser,
  input  logic                 cfg_wr,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int IDX_W  = (NUM_SATS > 1) ? $clog2(NUM_SATS) : 1;
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int ENT_W  = EPOCH_W + MW_W + CNT_W;
  localparam int NUM_SLOT_CODES = 2 ** SAT_IDX_W;
  localparam logic [CNT_W-1:0] WIN_MAX_C = CNT_W'(WINDOW_MAX);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

  // configuration
  logic [THR_W-1:0] slip_threshold;
  logic [GAP_W-1:0] max_gap_ms;
  logic [SYS_W-1:0] wanted_system;
  logic             drop_missing;

  always_ff @(posedge clk) begin
    if (rst) begin
      slip_threshold <= SLIP_THRESHOLD_RST;
      max_gap_ms     <= MAX_GAP_MS_RST;
      wanted_system  <= WANTED_SYSTEM_RST;
      drop_missing   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_SLIP_THRESHOLD: slip_threshold <= cfg_data[THR_W-1:0];
        CFG_MAX_GAP_MS:     max_gap_ms     <= cfg_data[GAP_W-1:0];
        CFG_WANTED_SYSTEM:  wanted_system  <= cfg_data[SYS_W-1:0];
        CFG_DROP_MISSING:   drop_missing   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // slot index folding
  logic [IDX_W-1:0] slot_map [NUM_SLOT_CODES];
  for (genvar g = 0; g < NUM_SLOT_CODES; g++) begin : g_slot
    assign slot_map[g] = IDX_W'(g % NUM_SATS);
  end

  // latched observation
  logic [IDX_W-1:0]   idx;
  logic [SYS_W-1:0]   sys;
  logic [EPOCH_W-1:0] epoch;
  logic [MW_W-1:0]    mw;
  logic               present;
  logic [LLI_W-1:0]   lli1;
  logic [LLI_W-1:0]   lli2;
  logic               prior;

  // working registers
  logic [DEV_W-1:0] gap;
  logic [DEV_W-1:0] dev;
  logic [MW_W-1:0]  mean;
  logic [MW_W-1:0]  mean_new;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] cnt_new;
  logic             slip_res;
  logic             rej_res;
  logic             skip_res;
  logic [NUM_SATS-1:0] seen;

  state_t state, state_next;

  logic             accept;
  logic             out_free;
  logic             mem_rd;
  logic             mem_wr;
  logic [ENT_W-1:0] rd_data;
  logic [EPOCH_W-1:0] rd_epoch;
  logic [MW_W-1:0]    rd_mean;
  logic [CNT_W-1:0]   rd_cnt;

  logic             pass_through;
  logic             gap_slip;
  logic [DEV_W-1:0] abs_dev;
  logic             hard_slip;
  logic             dev_slip;
  logic             detect;
  logic             use_div;
  logic             div_start;
  logic             div_done;
  logic [DEV_W-1:0] div_quo;
  logic [DEV_W-1:0] step_val;

  assign accept   = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;
  assign {rd_epoch, rd_mean, rd_cnt} = rd_data;

  assign pass_through = (sys != wanted_system) | ~present;
  assign gap_slip  = ~gap[DEV_W-1] & (gap[EPOCH_W-1:0] > {8'd0, max_gap_ms});
  assign abs_dev   = dev[DEV_W-1] ? (~dev + DEV_W'(1)) : dev;
  assign hard_slip = ~seen[idx] | lli1[0] | lli2[0] | gap_slip;
  assign dev_slip  = (cnt_inc > CNT_ONE) & (abs_dev > {2'b00, slip_threshold});
  assign detect    = hard_slip | dev_slip;
  assign use_div   = ~detect & (cnt_inc > CNT_ONE);
  assign step_val  = dev[DEV_W-1] ? (~div_quo + DEV_W'(1)) : div_quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mem_rd     = 1'b0;
    mem_wr     = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = ST_READ;
      end
      ST_READ: begin
        mem_rd     = 1'b1;
        state_next = pass_through ? ST_DONE : ST_DIFF;
      end
      ST_DIFF: state_next = ST_TEST;
      ST_TEST: begin
        div_start  = use_div;
        state_next = use_div ? ST_DIV : ST_WRITE;
      end
      ST_DIV: begin
        if (div_done) state_next = ST_WRITE;
      end
      ST_WRITE: begin
        mem_wr     = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx     <= slot_map[s_tdata[SAT_IDX_W-1:0]];
      epoch   <= s_tdata[45:6];
      mw      <= s_tdata[85:46];
      lli1    <= s_tdata[88:86];
      lli2    <= s_tdata[91:89];
      prior   <= s_tdata[92];
      sys     <= s_tuser[2:0];
      present <= s_tuser[3];
    end
    case (state)
      ST_READ: begin
        slip_res <= prior;
        rej_res  <= (sys == wanted_system) & ~present & drop_missing;
        skip_res <= sys != wanted_system;
      end
      ST_DIFF: begin
        gap     <= {1'b0, epoch} - {1'b0, rd_epoch};
        dev     <= {mw[MW_W-1], mw} - {rd_mean[MW_W-1], rd_mean};
        mean    <= rd_mean;
        cnt_inc <= (rd_cnt < WIN_MAX_C) ? rd_cnt + CNT_ONE : rd_cnt;
      end
      ST_TEST: begin
        cnt_new  <= detect ? CNT_ONE : cnt_inc;
        slip_res <= prior | detect;
        mean_new <= mw;
      end
      ST_DIV: begin
        if (div_done) mean_new <= mean + step_val[MW_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (mem_wr) begin
      seen[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= {7'd0, slip_res};
      m_tuser <= {skip_res, rej_res};
    end
  end

  mwcs_mem #(
    .DEPTH  (NUM_SATS),
    .ADDR_W (IDX_W),
    .DATA_W (ENT_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (idx),
    .wr_data ({epoch, mean_new, cnt_new}),
    .rd_en   (mem_rd),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  mwcs_div #(
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (abs_dev),
    .den   (cnt_inc),
    .done  (div_done),
    .quo   (div_quo)
  );

`ifndef ASSERT_OFF
  a_accept_to_read: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_READ) && !s_tready)
    else $error("accepted transaction did not start a table read");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside the divide phase");

  a_seen_after_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |=> seen[$past(idx)])
    else $error("slot not marked seen after update");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("result both rejected and skipped");
`endif

endmodule
